@@ rtl/lsq_fit_pkg.sv @@
// Package for the least-squares line fit block.
// Holds sizes, codes, command/status structs and saturation helpers.
// No dependencies.
package lsq_fit_pkg;

  localparam int MAX_POINTS = 256;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic               last_point;
  } in_t;

  typedef struct packed {
    logic signed [31:0] slope;
    logic signed [31:0] intercept;
    logic [47:0]        residual_variance;
    logic [8:0]         points_used;
    logic [1:0]         fit_status;
  } out_t;

  typedef enum logic [1:0] {
    FS_OK    = 2'd0,
    FS_FEW   = 2'd1,
    FS_DEGEN = 2'd2,
    FS_OVF   = 2'd3
  } fit_status_t;

  typedef enum logic [2:0] {
    MO_NSXX, MO_SXSX, MO_NSXY, MO_SXSY, MO_SLSX, MO_PRED, MO_SQ
  } mul_op_t;

  typedef enum logic [1:0] {
    DO_SLOPE, DO_ICPT, DO_VAR
  } div_op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DRAIN1, S_DRAIN2, S_CHECK, S_NSXX, S_SXSX, S_DABS, S_DCMP,
    S_NSXY, S_SXSY, S_DSLOPE, S_SLSX, S_DICPT, S_READ, S_PRED, S_SQ,
    S_DVAR, S_DONE
  } state_t;

  typedef struct packed {
    logic    mul_start;
    mul_op_t mul_op;
    logic    div_start;
    div_op_t div_op;
    logic    clr_res;
    logic    rd_en;
    logic    idx_inc;
    logic    dabs_en;
    logic    finish;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic few;
    logic degen;
    logic idx_last;
  } dp_stat_t;

  // Signed saturation: in range when bits 127..31 all agree.
  function automatic logic [31:0] sat32(input logic [127:0] v);
    if (!v[127] && (v[126:31] != '0)) begin
      return 32'h7FFF_FFFF;
    end else if (v[127] && (v[126:31] != '1)) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // Unsigned saturation of a nonnegative value to 48 bits.
  function automatic logic [47:0] sat48(input logic [127:0] v);
    if (v[127:48] != '0) begin
      return '1;
    end
    return v[47:0];
  endfunction

endpackage

@@ rtl/least_squares_line_fit_residual.sv @@
// Top level of the least-squares line fit with residual variance.
// Joins lsq_fit_ctrl and lsq_fit_dp; uses lsq_fit_pkg.
//
// Input: drive in_data and raise start; a transaction is taken at each clock
// edge where start is high and busy is low. Points that are not the last are
// taken back to back, one per cycle, and busy stays low. Each kept point goes
// to a 256-entry point memory and into the running sums through a two-stage
// multiply-add pipeline; points beyond 256 are dropped and flagged as overflow.
// The point marked last_point raises busy and starts the fit: pipeline drain
// and check, four products and a slope division, one product and a division
// for the intercept, a residual pass over each stored point (memory read, two
// products) and a final division. A series with fewer than two points ends
// after the check, a degenerate one after the denominator check. Products and
// divisions run on the sequential multiplier and divider.
// Output: out_valid is high for one cycle with out_data; the receiver cannot
// stall, so take it then. busy falls in that same cycle.
// Config: cfg_we writes min_denominator; write it while busy is low.
// Reset (rst_n low, synchronous) clears the series and min_denominator.
module least_squares_line_fit_residual
  import lsq_fit_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_t         in_data,
  output logic        out_valid,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     accept;

  // Take a transaction only while the sequencer is idle.
  assign accept = start && !busy;

  lsq_fit_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .last_point (in_data.last_point),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy)
  );

  lsq_fit_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // A result is only produced at the end of a busy fit.
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) && !busy))
    else $error("result without a preceding fit");

  // Failed fits report zero slope, intercept and variance.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.fit_status == FS_FEW || out_data.fit_status == FS_DEGEN))
    |-> (out_data.slope == 0 && out_data.intercept == 0 &&
         out_data.residual_variance == 0))
    else $error("failed fit carries nonzero result");

  // Point count never exceeds the store depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.points_used <= 9'(MAX_POINTS)))
    else $error("points_used beyond store depth");

endmodule

@@ rtl/lsq_fit_mul.sv @@
// Radix-256 sequential multiplier, signed 64 x 64 -> signed 128.
// Uses lsq_fit_pkg.
module lsq_fit_mul
  import lsq_fit_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic         done,
  output logic [127:0] prod
);

  logic [63:0]  am_r, bm_r;
  logic [127:0] acc_r, res_r;
  logic [2:0]   cnt_r;
  logic         run_r, fin_r, done_r, neg_r;
  logic [71:0]  pp;

  assign pp = am_r * bm_r[63:56];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          run_r <= 1'b0;
          fin_r <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      am_r  <= a[63] ? (64'd0 - a) : a;
      bm_r  <= b[63] ? (64'd0 - b) : b;
      neg_r <= a[63] ^ b[63];
      acc_r <= '0;
    end else if (run_r) begin
      acc_r <= {acc_r[119:0], 8'h00} + {56'h0, pp};
      bm_r  <= {bm_r[55:0], 8'h00};
    end else if (fin_r) begin
      res_r <= neg_r ? (128'd0 - acc_r) : acc_r;
    end
  end

  assign done = done_r;
  assign prod = res_r;

endmodule

@@ rtl/lsq_fit_div.sv @@
// Restoring divider, signed 128 / signed 128, quotient truncated toward zero.
// One quotient bit per cycle. Uses lsq_fit_pkg.
module lsq_fit_div
  import lsq_fit_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [127:0] num,
  input  logic [127:0] den,
  output logic         done,
  output logic [127:0] quot
);

  logic [127:0] nm_r, dm_r, r_r, q_r, rs;
  logic [6:0]   cnt_r;
  logic         run_r, fin_r, done_r, neg_r, ge;

  assign rs = {r_r[126:0], nm_r[127]};
  assign ge = rs >= dm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'd127) begin
          run_r <= 1'b0;
          fin_r <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nm_r  <= num[127] ? (128'd0 - num) : num;
      dm_r  <= den[127] ? (128'd0 - den) : den;
      neg_r <= num[127] ^ den[127];
      r_r   <= '0;
    end else if (run_r) begin
      r_r  <= ge ? (rs - dm_r) : rs;
      nm_r <= {nm_r[126:0], ge};
    end else if (fin_r) begin
      q_r <= neg_r ? (128'd0 - nm_r) : nm_r;
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

@@ rtl/lsq_fit_ctrl.sv @@
// Sequencer for the line fit: drain, fit, residual pass, result.
// Drives lsq_fit_dp through dp_cmd_t / dp_stat_t from lsq_fit_pkg.
module lsq_fit_ctrl
  import lsq_fit_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     last_point,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy
);

  state_t state_r, state_nxt;
  logic   issued_r, issued_nxt;
  logic   mul_state, div_state;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      issued_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      issued_r <= issued_nxt;
    end
  end

  assign mul_state = (state_r == S_NSXX) || (state_r == S_SXSX) || (state_r == S_NSXY) ||
                     (state_r == S_SXSY) || (state_r == S_SLSX) || (state_r == S_PRED) ||
                     (state_r == S_SQ);
  assign div_state = (state_r == S_DSLOPE) || (state_r == S_DICPT) || (state_r == S_DVAR);

  // Next state
  always_comb begin
    state_nxt  = state_r;
    issued_nxt = issued_r;
    if ((mul_state || div_state) && !issued_r) begin
      issued_nxt = 1'b1;
    end
    if ((mul_state && stat.mul_done) || (div_state && stat.div_done)) begin
      issued_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE:   if (start && last_point) state_nxt = S_DRAIN1;
      S_DRAIN1: state_nxt = S_DRAIN2;
      S_DRAIN2: state_nxt = S_CHECK;
      S_CHECK:  state_nxt = stat.few ? S_DONE : S_NSXX;
      S_NSXX:   if (stat.mul_done) state_nxt = S_SXSX;
      S_SXSX:   if (stat.mul_done) state_nxt = S_DABS;
      S_DABS:   state_nxt = S_DCMP;
      S_DCMP:   state_nxt = stat.degen ? S_DONE : S_NSXY;
      S_NSXY:   if (stat.mul_done) state_nxt = S_SXSY;
      S_SXSY:   if (stat.mul_done) state_nxt = S_DSLOPE;
      S_DSLOPE: if (stat.div_done) state_nxt = S_SLSX;
      S_SLSX:   if (stat.mul_done) state_nxt = S_DICPT;
      S_DICPT:  if (stat.div_done) state_nxt = S_READ;
      S_READ:   state_nxt = S_PRED;
      S_PRED:   if (stat.mul_done) state_nxt = S_SQ;
      S_SQ:     if (stat.mul_done) state_nxt = stat.idx_last ? S_DVAR : S_READ;
      S_DVAR:   if (stat.div_done) state_nxt = S_DONE;
      S_DONE:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd           = '0;
    cmd.mul_op    = MO_NSXX;
    cmd.div_op    = DO_SLOPE;
    cmd.mul_start = mul_state && !issued_r;
    cmd.div_start = div_state && !issued_r;
    unique case (state_r)
      S_CHECK:  cmd.clr_res = 1'b1;
      S_NSXX:   cmd.mul_op  = MO_NSXX;
      S_SXSX:   cmd.mul_op  = MO_SXSX;
      S_DABS:   cmd.dabs_en = 1'b1;
      S_NSXY:   cmd.mul_op  = MO_NSXY;
      S_SXSY:   cmd.mul_op  = MO_SXSY;
      S_DSLOPE: cmd.div_op  = DO_SLOPE;
      S_SLSX:   cmd.mul_op  = MO_SLSX;
      S_DICPT:  cmd.div_op  = DO_ICPT;
      S_READ:   cmd.rd_en   = 1'b1;
      S_PRED:   cmd.mul_op  = MO_PRED;
      S_SQ: begin
        cmd.mul_op  = MO_SQ;
        cmd.idx_inc = stat.mul_done && !stat.idx_last;
      end
      S_DVAR:   cmd.div_op  = DO_VAR;
      S_DONE:   cmd.finish  = 1'b1;
      default:  ;
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

@@ rtl/lsq_fit_dp.sv @@
// Datapath: point store, running sums, fit registers and result register.
// Instantiates lsq_fit_mul and lsq_fit_div; uses lsq_fit_pkg.
module lsq_fit_dp
  import lsq_fit_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  in_t         in_data,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  output logic        out_valid,
  output out_t        out_data
);

  logic [63:0] mem [MAX_POINTS];
  logic [63:0] rdata_r;

  logic [CNT_W-1:0]  count_r;
  logic [ADDR_W-1:0] idx_r;
  logic              ovf_r;
  logic [31:0]       min_r;

  logic signed [31:0] s1_x_r, s1_y_r;
  logic               s1_v_r, s2_v_r;
  logic signed [63:0] pxy_r, pxx_r;
  logic [47:0]        sx_r, sy_r;
  logic [63:0]        sxy_r, sxx_r;

  logic [127:0] pa_r, den_r, num_r, dabs_r, acc_r;
  logic [63:0]  d_r, k_r;
  logic [31:0]  slope_r, icpt_r;
  logic [47:0]  var_r;
  mul_op_t      mop_r;
  div_op_t      dop_r;

  logic         out_valid_r;
  out_t         out_r;

  logic [63:0]  mul_a, mul_b;
  logic [127:0] div_n, div_d, prod, quot, n_shift;
  logic         mul_done, div_done, kept, degen;
  logic [31:0]  q_sat;
  fit_status_t  status;

  assign kept    = accept && (count_r < CNT_W'(MAX_POINTS));
  assign n_shift = {{(112-CNT_W){1'b0}}, count_r, 16'h0};
  assign q_sat   = sat32(quot);

  // Store kept points and count them.
  always_ff @(posedge clk) begin
    if (kept) begin
      mem[count_r[ADDR_W-1:0]] <= {in_data.point_x, in_data.point_y};
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      min_r   <= '0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      sx_r    <= '0;
      sy_r    <= '0;
      sxy_r   <= '0;
      sxx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) min_r <= cfg_wdata;
      s1_v_r <= kept;
      s2_v_r <= s1_v_r;
      if (kept) begin
        count_r <= count_r + CNT_W'(1);
      end else if (accept) begin
        ovf_r <= 1'b1;
      end
      if (s1_v_r) begin
        sx_r <= sx_r + {{16{s1_x_r[31]}}, s1_x_r};
        sy_r <= sy_r + {{16{s1_y_r[31]}}, s1_y_r};
      end
      if (s2_v_r) begin
        sxy_r <= sxy_r + {{16{pxy_r[63]}}, pxy_r[63:16]};
        sxx_r <= sxx_r + {{16{pxx_r[63]}}, pxx_r[63:16]};
      end
      out_valid_r <= cmd.finish;
      if (cmd.finish) begin
        count_r <= '0;
        ovf_r   <= 1'b0;
        sx_r    <= '0;
        sy_r    <= '0;
        sxy_r   <= '0;
        sxx_r   <= '0;
      end
    end
  end

  // Accumulation pipeline payload.
  always_ff @(posedge clk) begin
    if (kept) begin
      s1_x_r <= in_data.point_x;
      s1_y_r <= in_data.point_y;
    end
    if (s1_v_r) begin
      pxy_r <= s1_x_r * s1_y_r;
      pxx_r <= s1_x_r * s1_x_r;
    end
  end

  // Operand selection for the shared multiplier and divider.
  always_comb begin
    case (cmd.mul_op)
      MO_NSXX: begin mul_a = {{(64-CNT_W){1'b0}}, count_r}; mul_b = sxx_r; end
      MO_NSXY: begin mul_a = {{(64-CNT_W){1'b0}}, count_r}; mul_b = sxy_r; end
      MO_SXSX: begin mul_a = {{16{sx_r[47]}}, sx_r}; mul_b = {{16{sx_r[47]}}, sx_r}; end
      MO_SXSY: begin mul_a = {{16{sx_r[47]}}, sx_r}; mul_b = {{16{sy_r[47]}}, sy_r}; end
      MO_SLSX: begin mul_a = {{32{slope_r[31]}}, slope_r}; mul_b = {{16{sx_r[47]}}, sx_r}; end
      MO_PRED: begin
        mul_a = {{32{slope_r[31]}}, slope_r};
        mul_b = {{32{rdata_r[63]}}, rdata_r[63:32]};
      end
      MO_SQ:   begin mul_a = d_r; mul_b = d_r; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_comb begin
    case (cmd.div_op)
      DO_SLOPE: begin div_n = {num_r[111:0], 16'h0}; div_d = den_r; end
      DO_ICPT:  begin div_n = pa_r;  div_d = n_shift; end
      DO_VAR:   begin div_n = acc_r; div_d = n_shift; end
      default:  begin div_n = '0;    div_d = n_shift; end
    endcase
  end

  lsq_fit_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  lsq_fit_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_n),
    .den   (div_d),
    .done  (div_done),
    .quot  (quot)
  );

  // Fit registers: capture each product or quotient by the operation issued.
  always_ff @(posedge clk) begin
    if (cmd.mul_start) mop_r <= cmd.mul_op;
    if (cmd.div_start) dop_r <= cmd.div_op;
    if (cmd.dabs_en)   dabs_r <= den_r[127] ? (128'd0 - den_r) : den_r;
    if (cmd.clr_res) begin
      slope_r <= '0;
      icpt_r  <= '0;
      var_r   <= '0;
      acc_r   <= '0;
    end
    if (mul_done) begin
      case (mop_r)
        MO_NSXX, MO_NSXY: pa_r <= prod;
        MO_SXSX: den_r <= {pa_r[111:0], 16'h0} - prod;
        MO_SXSY: num_r <= {pa_r[111:0], 16'h0} - prod;
        MO_SLSX: pa_r  <= {{64{sy_r[47]}}, sy_r, 16'h0} - prod;
        MO_PRED: d_r   <= {{16{rdata_r[31]}}, rdata_r[31:0], 16'h0} - k_r - prod[63:0];
        MO_SQ:   acc_r <= acc_r + {32'h0, prod[127:32]};
        default: ;
      endcase
    end
    if (div_done) begin
      case (dop_r)
        DO_SLOPE: slope_r <= q_sat;
        DO_ICPT: begin
          icpt_r <= q_sat;
          k_r    <= {{16{q_sat[31]}}, q_sat, 16'h0};
        end
        DO_VAR:  var_r <= sat48(quot);
        default: ;
      endcase
    end
  end

  // Residual pass index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.clr_res) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + ADDR_W'(1);
    end
  end

  assign degen = dabs_r <= {96'h0, min_r};

  always_comb begin
    if (count_r < CNT_W'(2))  status = FS_FEW;
    else if (degen)           status = FS_DEGEN;
    else if (ovf_r)           status = FS_OVF;
    else                      status = FS_OK;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_r.slope             <= slope_r;
      out_r.intercept         <= icpt_r;
      out_r.residual_variance <= var_r;
      out_r.points_used       <= 9'(count_r);
      out_r.fit_status        <= status;
    end
  end

  assign stat.mul_done = mul_done;
  assign stat.div_done = div_done;
  assign stat.few      = count_r < CNT_W'(2);
  assign stat.degen    = degen;
  assign stat.idx_last = ({1'b0, idx_r} == (count_r - CNT_W'(1)));

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
